/* src/prg_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the program header parser.
// No dependencies; imported by every module of the block.
package prg_pkg;

   localparam int SCAN_WINDOW      = 40;
   localparam int CONTAINER_HEADER = 26;

   localparam int COUNT_W = 17;
   localparam int DIGIT_W = 17;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1ffff;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 17'h1ffff;

   // First byte index of each reading's program data, and its scan window end
   localparam logic [COUNT_W-1:0] PLAIN_DATA   = 17'd2;
   localparam logic [COUNT_W-1:0] CONT_DATA    = COUNT_W'(CONTAINER_HEADER + 2);
   localparam logic [COUNT_W-1:0] PLAIN_WIN_END = COUNT_W'(2 + SCAN_WINDOW);
   localparam logic [COUNT_W-1:0] CONT_WIN_END  = COUNT_W'(CONTAINER_HEADER + 2 + SCAN_WINDOW);
   localparam logic [COUNT_W-1:0] CONT_LOAD_LO = COUNT_W'(CONTAINER_HEADER);
   localparam logic [COUNT_W-1:0] CONT_LOAD_HI = COUNT_W'(CONTAINER_HEADER + 1);
   localparam logic [COUNT_W-1:0] SIG_LEN      = 17'd8;
   localparam logic [COUNT_W-1:0] MIN_PLAIN    = 17'd3;
   localparam logic [COUNT_W-1:0] MIN_CONT     = COUNT_W'(CONTAINER_HEADER + 3);

   localparam logic [7:0] SYS_TOKEN  = 8'h9e;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] ZERO_CHAR  = 8'h30;
   localparam logic [7:0] NINE_CHAR  = 8'h39;

   typedef enum logic [1:0] {
      SCAN_SEEK  = 2'd0,
      SCAN_SPACE = 2'd1,
      SCAN_DIGIT = 2'd2,
      SCAN_DONE  = 2'd3
   } scan_phase_type;

   typedef struct packed {
      logic        found;
      logic [15:0] addr;
   } scan_res_type;

   typedef struct packed {
      logic        file_valid;
      logic        container_form;
      logic [15:0] load_address;
      logic [15:0] end_address;
      logic [16:0] program_size;
      logic        start_found;
      logic [15:0] start_address;
   } summary_type;

   // Signature bytes "C64File" plus a zero byte
   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h43;
         3'd1:    b = 8'h36;
         3'd2:    b = 8'h34;
         3'd3:    b = 8'h46;
         3'd4:    b = 8'h69;
         3'd5:    b = 8'h6c;
         3'd6:    b = 8'h65;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* src/prg_scan.sv */
`timescale 1ns / 1ps
// One start-line scanner: seeks the SYS token, skips spaces, accumulates digits.
// Depends on prg_pkg.
module prg_scan
   import prg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         clear,
   input  logic         feed,
   input  logic         in_window,
   input  logic [7:0]   file_byte,
   output scan_res_type res
);

   scan_phase_type     phase_ff, phase_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic               hit_ff, hit_in;
   logic [15:0]        value_ff, value_in;

   logic               is_digit;
   logic               seek_now;
   logic [3:0]         dval;
   logic [DIGIT_W+3:0] prod;

   always_comb begin
      is_digit = (file_byte >= ZERO_CHAR) && (file_byte <= NINE_CHAR);
      dval     = 4'(file_byte - ZERO_CHAR);
      prod     = ((DIGIT_W+4)'(digit_ff) << 3) + ((DIGIT_W+4)'(digit_ff) << 1)
                 + (DIGIT_W+4)'(dval);
      phase_in = phase_ff;
      digit_in = digit_ff;
      hit_in   = hit_ff;
      value_in = value_ff;
      seek_now = 1'b0;
      if (feed) begin
         case (phase_ff)
            SCAN_DONE: begin
            end
            SCAN_SPACE: begin
               if (file_byte == SPACE_CHAR) begin
               end else if (is_digit) begin
                  digit_in = DIGIT_W'(dval);
                  phase_in = SCAN_DIGIT;
               end else begin
                  seek_now = 1'b1;
               end
            end
            SCAN_DIGIT: begin
               if (is_digit) begin
                  // saturate instead of wrapping
                  digit_in = (prod > (DIGIT_W+4)'(DIGIT_MAX)) ? DIGIT_MAX : prod[DIGIT_W-1:0];
               end else if (digit_ff[DIGIT_W-1] == 1'b0) begin
                  hit_in   = 1'b1;
                  value_in = digit_ff[15:0];
                  phase_in = SCAN_DONE;
               end else begin
                  seek_now = 1'b1;
               end
            end
            default: begin
               seek_now = 1'b1;
            end
         endcase
         // the byte that ended a failed run is examined as a token too
         if (seek_now) begin
            phase_in = SCAN_SEEK;
            if (in_window && file_byte == SYS_TOKEN) begin
               phase_in = SCAN_SPACE;
               digit_in = '0;
            end
         end
      end
      // a digit run ending with the file counts as ended
      res.found = hit_in || (phase_in == SCAN_DIGIT && digit_in[DIGIT_W-1] == 1'b0);
      res.addr  = hit_in ? value_in : (res.found ? digit_in[15:0] : 16'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SCAN_SEEK;
         digit_ff <= '0;
         hit_ff   <= 1'b0;
         value_ff <= '0;
      end else if (advance) begin
         if (clear) begin
            phase_ff <= SCAN_SEEK;
            digit_ff <= '0;
            hit_ff   <= 1'b0;
            value_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            digit_ff <= digit_in;
            hit_ff   <= hit_in;
            value_ff <= value_in;
         end
      end
   end

endmodule

/* src/prg_summary.sv */
`timescale 1ns / 1ps
// Final-byte evaluation: picks the reading, checks length and address range.
// Depends on prg_pkg.
module prg_summary
   import prg_pkg::*;
(
   input  logic [COUNT_W-1:0] file_len,
   input  logic               sig_ok,
   input  logic [15:0]        plain_load,
   input  logic [15:0]        cont_load,
   input  scan_res_type       plain_scan,
   input  scan_res_type       cont_scan,
   output summary_type        summary
);

   logic               container;
   logic               len_ok;
   logic               use_cont;
   logic [15:0]        load;
   logic [COUNT_W-1:0] size;
   logic [COUNT_W:0]   reach;
   logic               valid;
   scan_res_type       pick;

   always_comb begin
      container = sig_ok && (file_len >= CONT_DATA);
      use_cont  = container;
      if (container) begin
         len_ok = file_len >= MIN_CONT;
         load   = cont_load;
         size   = file_len - CONT_DATA;
      end else begin
         len_ok = file_len >= MIN_PLAIN;
         load   = plain_load;
         size   = file_len - PLAIN_DATA;
      end
      reach = (COUNT_W+1)'(load) + (COUNT_W+1)'(size);
      valid = len_ok && (reach <= (COUNT_W+1)'(18'h10000));
      pick  = use_cont ? cont_scan : plain_scan;

      summary.file_valid     = valid;
      summary.container_form = container;
      summary.load_address   = valid ? load : 16'd0;
      summary.end_address    = valid ? 16'(reach - (COUNT_W+1)'(1)) : 16'd0;
      summary.program_size   = valid ? size : '0;
      summary.start_found    = valid && pick.found;
      summary.start_address  = (valid && pick.found) ? pick.addr : 16'd0;
   end

endmodule

/* src/prg_program_header_parser.sv */
`timescale 1ns / 1ps
// Top level of the program file header parser: input register, header state,
// two scanners and the result register. Depends on prg_pkg, prg_scan, prg_summary.
//
//   channel | ports            | direction | carries
//   --------+------------------+-----------+------------------------------------
//   req     | req_valid/ready  | in        | one file byte, last-byte flag
//   rsp     | rsp_valid/ready  | out       | header summary, once per file
//
// One byte per cycle sustained: a byte is registered at the input, applied to
// the header state and scanners from that register, and a final byte loads the
// result register in that same cycle. Input stalls only when a final byte waits
// behind an untaken result. Synchronous reset clears the count and scanners and
// sets the signature flag.
module prg_program_header_parser
   import prg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_file_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_file_valid,
   output logic        rsp_container_form,
   output logic [15:0] rsp_load_address,
   output logic [15:0] rsp_end_address,
   output logic [16:0] rsp_program_size,
   output logic        rsp_start_found,
   output logic [15:0] rsp_start_address
);

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   logic               advance;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               sig_ok_ff, sig_ok_in;
   logic [15:0]        plain_load_ff, plain_load_in;
   logic [15:0]        cont_load_ff, cont_load_in;

   scan_res_type       plain_res, cont_res;
   summary_type        summary;

   logic               rsp_valid_ff;
   summary_type        rsp_data_ff;

   logic plain_feed, plain_win, cont_feed, cont_win;

   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_byte_ff <= req_file_byte;
         in_last_ff <= req_final_byte;
      end
   end

   always_comb begin
      count_in      = (count_ff < COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
      sig_ok_in     = sig_ok_ff;
      plain_load_in = plain_load_ff;
      cont_load_in  = cont_load_ff;
      if (count_ff < SIG_LEN && in_byte_ff != sig_byte(count_ff[2:0])) begin
         sig_ok_in = 1'b0;
      end
      if (count_ff == '0)           plain_load_in[7:0]  = in_byte_ff;
      if (count_ff == COUNT_W'(1))  plain_load_in[15:8] = in_byte_ff;
      if (count_ff == CONT_LOAD_LO) cont_load_in[7:0]   = in_byte_ff;
      if (count_ff == CONT_LOAD_HI) cont_load_in[15:8]  = in_byte_ff;
      plain_feed = count_ff >= PLAIN_DATA;
      plain_win  = count_ff < PLAIN_WIN_END;
      cont_feed  = count_ff >= CONT_DATA;
      cont_win   = count_ff < CONT_WIN_END;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sig_ok_ff     <= 1'b1;
         plain_load_ff <= '0;
         cont_load_ff  <= '0;
      end else if (advance) begin
         if (in_last_ff) begin
            // file done: return to the reset values for the next file
            count_ff      <= '0;
            sig_ok_ff     <= 1'b1;
            plain_load_ff <= '0;
            cont_load_ff  <= '0;
         end else begin
            count_ff      <= count_in;
            sig_ok_ff     <= sig_ok_in;
            plain_load_ff <= plain_load_in;
            cont_load_ff  <= cont_load_in;
         end
      end
   end

   prg_scan u_plain_scan (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .clear     (in_last_ff),
      .feed      (plain_feed),
      .in_window (plain_win),
      .file_byte (in_byte_ff),
      .res       (plain_res)
   );

   prg_scan u_cont_scan (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .clear     (in_last_ff),
      .feed      (cont_feed),
      .in_window (cont_win),
      .file_byte (in_byte_ff),
      .res       (cont_res)
   );

   prg_summary u_summary (
      .file_len   (count_in),
      .sig_ok     (sig_ok_in),
      .plain_load (plain_load_in),
      .cont_load  (cont_load_in),
      .plain_scan (plain_res),
      .cont_scan  (cont_res),
      .summary    (summary)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= summary;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_file_valid     = rsp_data_ff.file_valid;
   assign rsp_container_form = rsp_data_ff.container_form;
   assign rsp_load_address   = rsp_data_ff.load_address;
   assign rsp_end_address    = rsp_data_ff.end_address;
   assign rsp_program_size   = rsp_data_ff.program_size;
   assign rsp_start_found    = rsp_data_ff.start_found;
   assign rsp_start_address  = rsp_data_ff.start_address;

`ifndef SYNTHESIS
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> count_ff == '0 && sig_ok_ff)
      else $error("state not cleared after final item");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a blocked result");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.file_valid |->
         rsp_data_ff.load_address == 16'd0 && rsp_data_ff.program_size == '0 &&
         rsp_data_ff.start_found == 1'b0)
      else $error("invalid file with nonzero fields");

   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.file_valid |->
         (18'(rsp_data_ff.load_address) + 18'(rsp_data_ff.program_size)) <= 18'h10000
         && rsp_data_ff.program_size != '0)
      else $error("valid file beyond address range");
`endif

endmodule
